### hdl/power_toggle_color_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power toggle color sequencer
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef POWER_TOGGLE_COLOR_SEQUENCER_CORE_MACROS_SVH
`define POWER_TOGGLE_COLOR_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PTCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ptcs assertion failed");
// next-cycle implication
`define PTCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ptcs assertion failed");
`else
`define PTCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PTCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/ptcs_pkg.sv
// ----------------------------------------------------------------------------
// ptcs_pkg
// Shared types and constants for the power toggle color sequencer.
// ----------------------------------------------------------------------------
package ptcs_pkg;

    localparam int OP_W       = 3;
    localparam int COLOR_W    = 4;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PULSE_W    = 2;
    localparam int NUM_COLORS_DEF = 8;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_POWER  = 3'd1;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_SYNC   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE  = 2'd2;

    localparam logic [TICK_W-1:0] TOGGLE_RST = 16'd200;
    localparam logic [TICK_W-1:0] QUIET_RST  = 16'd5500;
    localparam logic [TICK_W-1:0] PULSE_RST  = 16'd250;

    localparam logic [PULSE_W-1:0] SYNC_PULSES = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CC_LOW  = 3'd1,
        PH_CC_HIGH = 3'd2,
        PH_QUIET1  = 3'd3,
        PH_PHIGH   = 3'd4,
        PH_PLOW    = 3'd5,
        PH_QUIET2  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] toggle_ticks;
        logic [TICK_W-1:0] quiet_ticks;
        logic [TICK_W-1:0] pulse_ticks;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic               on_request;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic               pin_level;
        logic [COLOR_W-1:0] color_now;
        logic               busy_res;
    } t_result;

endpackage

### hdl/ptcs_cfg.sv
// ----------------------------------------------------------------------------
// ptcs_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ptcs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ptcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptcs_pkg::TICK_W-1:0]        i_cfg_wdata,
    output ptcs_pkg::t_cfg                     o_cfg
);
    import ptcs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.toggle_ticks <= TOGGLE_RST;
            r_cfg.quiet_ticks  <= QUIET_RST;
            r_cfg.pulse_ticks  <= PULSE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TOGGLE: r_cfg.toggle_ticks <= i_cfg_wdata;
                REG_QUIET:  r_cfg.quiet_ticks  <= i_cfg_wdata;
                REG_PULSE:  r_cfg.pulse_ticks  <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/ptcs_in_stage.sv
// ----------------------------------------------------------------------------
// ptcs_in_stage
// Input register; holds one accepted item until the update stage takes it.
// ----------------------------------------------------------------------------
module ptcs_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ptcs_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_vld,
    output ptcs_pkg::t_item o_item
);
    import ptcs_pkg::*;

    logic  r_vld;
    t_item r_item;

    assign o_ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

### hdl/ptcs_fsm.sv
// ----------------------------------------------------------------------------
// ptcs_fsm
// Sequencer state and single-pass update for one item.
// ----------------------------------------------------------------------------
`include "power_toggle_color_sequencer_core_macros.svh"

module ptcs_fsm #(
    parameter int NUM_COLORS = ptcs_pkg::NUM_COLORS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ptcs_pkg::t_item   i_item,
    input  ptcs_pkg::t_cfg    i_cfg,
    output ptcs_pkg::t_result o_result
);
    import ptcs_pkg::*;

    localparam int HUE_W = $clog2(NUM_COLORS + 1);
    localparam int CMP_W = COLOR_W + 1;

    t_phase             r_phase,  n_phase;
    logic [TICK_W-1:0]  r_tick,   n_tick;
    logic [PULSE_W-1:0] r_pulses, n_pulses;
    logic [HUE_W-1:0]   r_cur,    n_cur;
    logic [HUE_W-1:0]   r_tgt,    n_tgt;
    logic               r_wanted, n_wanted;
    logic               r_pin,    n_pin;

    logic [TICK_W-1:0]  tick_inc;
    logic [TICK_W-1:0]  limit;
    logic               wait_done;
    logic [HUE_W-1:0]   hue_after;
    logic [HUE_W-1:0]   col_hue;
    logic               col_ok;

    assign tick_inc  = r_tick + TICK_W'(1);
    assign hue_after = (r_cur < HUE_W'(NUM_COLORS)) ? r_cur + HUE_W'(1) : HUE_W'(1);
    assign col_hue   = HUE_W'(i_item.color);
    assign col_ok    = (i_item.color != '0) &&
                       ({1'b0, i_item.color} <= CMP_W'(NUM_COLORS));

    always_comb begin
        case (r_phase)
            PH_CC_LOW, PH_CC_HIGH: limit = i_cfg.toggle_ticks;
            PH_QUIET1, PH_QUIET2:  limit = i_cfg.quiet_ticks;
            default:               limit = i_cfg.pulse_ticks;
        endcase
    end

    // a limit of zero behaves as one
    assign wait_done = tick_inc >= limit;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_pulses = r_pulses;
        n_cur    = r_cur;
        n_tgt    = r_tgt;
        n_wanted = r_wanted;
        n_pin    = r_pin;
        case (i_item.opcode)
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_tick = tick_inc;
                    if (wait_done) begin
                        n_tick = '0;
                        case (r_phase)
                            PH_CC_LOW: begin
                                n_cur = hue_after;
                                if (hue_after != r_tgt) begin
                                    n_phase = PH_CC_HIGH;
                                    n_pin   = 1'b1;
                                end else begin
                                    n_phase = PH_IDLE;
                                    n_pin   = r_wanted;
                                end
                            end
                            PH_CC_HIGH: begin
                                n_phase = PH_CC_LOW;
                                n_pin   = 1'b0;
                            end
                            PH_QUIET1: begin
                                n_pulses = SYNC_PULSES;
                                n_phase  = PH_PHIGH;
                                n_pin    = 1'b1;
                            end
                            PH_PHIGH: begin
                                n_pulses = r_pulses - PULSE_W'(1);
                                n_phase  = (r_pulses != PULSE_W'(1)) ? PH_PLOW : PH_QUIET2;
                                n_pin    = 1'b0;
                            end
                            PH_PLOW: begin
                                n_phase = PH_PHIGH;
                                n_pin   = 1'b1;
                            end
                            PH_QUIET2: begin
                                n_cur   = HUE_W'(1);
                                n_tgt   = HUE_W'(1);
                                n_phase = PH_IDLE;
                                n_pin   = r_wanted;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_POWER: begin
                n_wanted = i_item.on_request;
                if (r_phase == PH_IDLE) begin
                    n_pin = i_item.on_request;
                end
            end
            OP_SELECT: begin
                if (col_ok) begin
                    n_tgt = col_hue;
                    if (r_phase == PH_IDLE && r_cur != col_hue) begin
                        n_phase = PH_CC_LOW;
                        n_tick  = '0;
                        n_pin   = 1'b0;
                    end
                end
            end
            OP_NEXT: begin
                // the next color differs unless NUM_COLORS is one; an idle lamp always starts a change
                n_wanted = 1'b1;
                n_tgt    = hue_after;
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_CC_LOW;
                    n_tick  = '0;
                    n_pin   = 1'b0;
                end
            end
            OP_SYNC: begin
                n_tgt    = HUE_W'(1);
                n_pulses = '0;
                n_phase  = PH_QUIET1;
                n_tick   = '0;
                n_pin    = 1'b0;
            end
            default: ;
        endcase
    end

    // result of the item
    always_comb begin
        o_result.pin_level = n_pin;
        o_result.color_now = COLOR_W'(n_cur);
        o_result.busy_res  = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_pulses <= '0;
            r_cur    <= HUE_W'(1);
            r_tgt    <= HUE_W'(1);
            r_wanted <= 1'b0;
            r_pin    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_pulses <= n_pulses;
            r_cur    <= n_cur;
            r_tgt    <= n_tgt;
            r_wanted <= n_wanted;
            r_pin    <= n_pin;
        end
    end

    `PTCS_ASSERT_IMP(a_low_phases, i_clk, i_rst_n, (r_phase == PH_CC_LOW || r_phase == PH_QUIET1 || r_phase == PH_PLOW || r_phase == PH_QUIET2), !r_pin)
    `PTCS_ASSERT_IMP(a_high_phases, i_clk, i_rst_n, (r_phase == PH_CC_HIGH || r_phase == PH_PHIGH), r_pin)
    `PTCS_ASSERT_IMP(a_pulse_count, i_clk, i_rst_n, (r_phase == PH_PHIGH || r_phase == PH_PLOW), r_pulses != '0)
    `PTCS_ASSERT_IMP(a_idle_count, i_clk, i_rst_n, r_phase == PH_IDLE, r_tick == '0)
    `PTCS_ASSERT_NXT(a_sync_start, i_clk, i_rst_n, i_step && i_item.opcode == OP_SYNC, r_phase == PH_QUIET1 && r_tgt == HUE_W'(1))

endmodule

### hdl/ptcs_out_stage.sv
// ----------------------------------------------------------------------------
// ptcs_out_stage
// Result register; frees itself in the cycle its item is taken.
// ----------------------------------------------------------------------------
module ptcs_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ptcs_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output ptcs_pkg::t_result o_result
);
    import ptcs_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_res;

endmodule

### hdl/power_toggle_color_sequencer_core.sv
// Pipeline: an accepted item passes through the input register and then the result register,
// where its result waits until it is taken.
// Throughput: 1 item per cycle if i_ready is high; state update is one pass through ptcs_fsm.
// The input side keeps accepting while a result waits, until both registers are full.
// Reset: synchronous, active low; timing registers return to 200/5500/250,
// lamp off, color 1, no sequence running, both stages empty.
// ----------------------------------------------------------------------------
// power_toggle_color_sequencer_core
// Top level: lamp power pin sequencer for power-cycled color changes.
// ----------------------------------------------------------------------------
module power_toggle_color_sequencer_core #(
    parameter int NUM_COLORS = ptcs_pkg::NUM_COLORS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ptcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptcs_pkg::TICK_W-1:0]     i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ptcs_pkg::OP_W-1:0]       i_opcode,
    input  logic                            i_on_request,
    input  logic [ptcs_pkg::COLOR_W-1:0]    i_color,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_pin_level,
    output logic [ptcs_pkg::COLOR_W-1:0]    o_color_now,
    output logic                            o_busy_res
);
    import ptcs_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_item   stage_item;
    t_result step_res;
    t_result out_res;
    logic    stage_vld;
    logic    out_free;
    logic    step;

    assign in_item.opcode     = i_opcode;
    assign in_item.on_request = i_on_request;
    assign in_item.color      = i_color;

    assign step = stage_vld && out_free;

    ptcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ptcs_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (out_free),
        .o_vld     (stage_vld),
        .o_item    (stage_item)
    );

    ptcs_fsm #(
        .NUM_COLORS (NUM_COLORS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (stage_item),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    ptcs_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (step_res),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_res)
    );

    assign o_pin_level = out_res.pin_level;
    assign o_color_now = out_res.color_now;
    assign o_busy_res  = out_res.busy_res;

endmodule
